// ===== src/tssd_pkg.sv =====
// Shared types and constants for the two-digit temperature display.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tssd_pkg;

    // Fixed field widths.
    localparam int MV_W      = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int TEMP_W    = 8;
    localparam int SEG_W     = 8;

    // Difference between average and zero offset, one bit above a sample.
    localparam int D_W = MV_W + 1;

    // Default parameter values for the top level.
    localparam int DEF_SAMPLES_PER_BURST = 100;
    localparam int DEF_TICKS_PER_UPDATE  = 100;
    localparam int DEF_SAMPLE_BITS       = 12;

    // Depth of the queue between front and back (a power of two).
    localparam int Q_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEX_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 1'b1;

    // Reset values of the architectural state.
    localparam logic [MV_W-1:0]   ZERO_OFFSET_RST = 12'd500;
    localparam logic [TEMP_W-1:0] TEMP_RST        = 8'd99;
    localparam logic [SEG_W-1:0]  SEG_BLANK       = 8'hFF;
    localparam logic [TEMP_W-1:0] TEMP_MAX        = 8'd255;

    // Divide by ten through a reciprocal: exact for values below 43690.
    localparam logic [15:0] RECIP10       = 16'd52429;
    localparam int          RECIP10_SHIFT = 19;
    localparam int          PROD_W        = D_W + 16;
    localparam int          Q10_W         = PROD_W - RECIP10_SHIFT;

    // Digit split of an eight-bit temperature: (t * 205) >> 11 == t / 10.
    localparam logic [7:0] DIG_RECIP = 8'd205;
    localparam int         DIG_SHIFT = 11;

    // Sample bits actually kept, never more than the sample field holds.
    function automatic int SAMPLE_BITS_EFF(input int bits);
        return (bits < MV_W) ? bits : MV_W;
    endfunction

    // Active-low segment patterns, bit 7 is the decimal point.
    function automatic logic [SEG_W-1:0] seg_glyph(input logic [3:0] digit);
        logic [SEG_W-1:0] glyph;
        unique case (digit)
            4'h0: glyph = 8'hC0;
            4'h1: glyph = 8'hF9;
            4'h2: glyph = 8'hA4;
            4'h3: glyph = 8'hB0;
            4'h4: glyph = 8'h99;
            4'h5: glyph = 8'h92;
            4'h6: glyph = 8'h82;
            4'h7: glyph = 8'hF8;
            4'h8: glyph = 8'h80;
            4'h9: glyph = 8'h90;
            4'hA: glyph = 8'h08;
            4'hB: glyph = 8'h03;
            4'hC: glyph = 8'h46;
            4'hD: glyph = 8'h21;
            4'hE: glyph = 8'h06;
            4'hF: glyph = 8'h0E;
        endcase
        return glyph;
    endfunction

    typedef enum logic [0:0] {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // One classified item as it waits in the queue.
    typedef struct packed {
        t_op             op;
        logic [MV_W-1:0] mv;
    } t_item;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic            hex_mode;
        logic [MV_W-1:0] zero_offset_mv;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/tssd_front.sv =====
// Front end: accepts input transfers, classifies them and queues them.
// Depends on tssd_pkg for the item type and the queue depth.
`default_nettype none

module tssd_front import tssd_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic            i_op,
    input  wire logic [MV_W-1:0] i_sample_mv,
    output logic                 o_q_valid,
    output t_item                o_q_item,
    input  wire logic            i_q_pop
);

    localparam int EFF_W = (SAMPLE_BITS < MV_W) ? SAMPLE_BITS : MV_W;
    localparam logic [MV_W-1:0] MV_MASK = MV_W'((32'd1 << EFF_W) - 32'd1);
    localparam int QA_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_item            r_mem [Q_DEPTH];
    logic [QA_W-1:0]  r_wr_ptr;
    logic [QA_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]  r_count;
    logic             full;
    logic             push;
    t_item            item_in;

    // Classify the incoming transfer and mask the sample to its valid bits.
    always_comb begin
        item_in.op = t_op'(i_op);
        item_in.mv = (t_op'(i_op) == OP_SAMPLE) ? (i_sample_mv & MV_MASK) : '0;
    end

    assign full      = (r_count == QC_W'(Q_DEPTH));
    assign push      = i_valid && !full;
    assign o_stall   = full;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, i_q_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/tssd_div.sv =====
// Divider by a fixed divisor through reciprocal multiplication, registered per stage.
// Depends on tssd_pkg for the default divisor.
`default_nettype none

module tssd_div import tssd_pkg::*; #(
    parameter int DIVIDEND_W = 19,
    parameter int DIVISOR    = DEF_SAMPLES_PER_BURST,
    parameter int DIVISOR_W  = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    output logic                       o_done,
    output logic [DIVIDEND_W-1:0]      o_quotient,
    output logic [DIVISOR_W-1:0]       o_remainder
);

    // The rounded-up reciprocal gives the exact floor for every dividend value.
    localparam int RSH   = DIVIDEND_W + $clog2(DIVISOR);
    localparam int M_W   = DIVIDEND_W + 1;
    localparam int MUL_W = DIVIDEND_W + M_W;
    localparam logic [M_W-1:0] RECIP_M =
        M_W'(((64'd1 << RSH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [DIVIDEND_W-1:0] r_arg;
    logic [MUL_W-1:0]      r_prod;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic                  r_prod_ok;
    logic                  r_quo_ok;
    logic                  r_done;
    logic [DIVIDEND_W-1:0] quo_times_div;
    logic [DIVIDEND_W-1:0] rem_full;

    // Remainder from the quotient and the original dividend.
    always_comb begin
        quo_times_div = DIVIDEND_W'(r_quo * DIVIDEND_W'(DIVISOR));
        rem_full      = r_arg - quo_times_div;
    end

    // Stage sequencer: product, quotient, remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_ok <= 1'b0;
            r_quo_ok  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_prod_ok <= i_start;
            r_quo_ok  <= r_prod_ok;
            r_done    <= r_quo_ok;
        end
    end

    // Datapath registers of the three stages.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_arg  <= i_dividend;
            r_prod <= MUL_W'(i_dividend) * MUL_W'(RECIP_M);
        end
        if (r_prod_ok) begin
            r_quo <= DIVIDEND_W'(r_prod >> RSH);
        end
        if (r_quo_ok) begin
            r_rem <= rem_full[DIVISOR_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ===== src/tssd_back.sv =====
// Back end: runs ticks and samples, converts bursts, drives the result.
// Depends on tssd_pkg; works with tssd_div for the burst average.
`default_nettype none

module tssd_back import tssd_pkg::*; #(
    parameter int SAMPLES_PER_BURST = DEF_SAMPLES_PER_BURST,
    parameter int TICKS_PER_UPDATE  = DEF_TICKS_PER_UPDATE,
    parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_q_valid,
    input  wire t_item             i_q_item,
    output logic                   o_q_pop,
    output logic                   o_div_start,
    output logic [SAMPLE_BITS_EFF(SAMPLE_BITS) + $clog2(SAMPLES_PER_BURST + 1) - 1:0]
                                   o_div_dividend,
    input  wire logic              i_div_done,
    input  wire logic [SAMPLE_BITS_EFF(SAMPLE_BITS) + $clog2(SAMPLES_PER_BURST + 1) - 1:0]
                                   i_div_quotient,
    input  wire logic [$clog2(SAMPLES_PER_BURST + 1)-1:0] i_div_remainder,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [SEG_W-1:0]       o_segments,
    output logic                   o_tens_on,
    output logic                   o_ones_on,
    output logic                   o_conversion_request,
    output logic [TEMP_W-1:0]      o_temperature_c,
    output logic                   o_update_done
);

    localparam int EFF_W = SAMPLE_BITS_EFF(SAMPLE_BITS);
    localparam int CNT_W = $clog2(SAMPLES_PER_BURST + 1);
    localparam int SUM_W = EFF_W + CNT_W;
    localparam int TCK_W = $clog2(TICKS_PER_UPDATE + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCALE,
        S_ROUND
    } t_state;

    t_state              r_state;
    logic [TCK_W-1:0]    r_tick;
    logic                r_high_next;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_samples;
    logic [TEMP_W-1:0]   r_temp;
    logic [SEG_W-1:0]    r_seg;
    logic [1:0]          r_en;
    logic                r_out_valid;
    logic                r_o_req;
    logic                r_o_done;
    logic                r_div_start;
    logic [SUM_W-1:0]    r_div_arg;
    logic [D_W-1:0]      r_d;
    logic [PROD_W-1:0]   r_prod;

    logic                out_free;
    logic                pop;
    logic                burst_pop;
    logic                out_load;
    logic                tick_wrap;
    logic [SUM_W-1:0]    sum_new;
    logic [CNT_W-1:0]    cnt_new;
    logic                burst_end;
    logic [15:0]         dig_prod;
    logic [4:0]          dec_q;
    logic [7:0]          dec_r;
    logic [4:0]          digit;
    logic [SEG_W-1:0]    seg_next;
    logic                round_up;
    logic [D_W-1:0]      avg;
    logic [D_W-1:0]      zero_ext;
    logic [D_W-1:0]      d_next;
    logic [Q10_W-1:0]    q10;
    logic [D_W-1:0]      rem10;
    logic [Q10_W-1:0]    t_full;
    logic [TEMP_W-1:0]   t_sat;

    // The output register is free once empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_stall;
    assign pop      = (r_state == S_IDLE) && i_q_valid && out_free;

    // A sample that ends a burst starts the divider; every other item loads the result.
    assign burst_pop = pop && (i_q_item.op == OP_SAMPLE) && burst_end;
    assign out_load  = (pop && !burst_pop) || ((r_state == S_ROUND) && out_free);

    // Tick counter and sample accumulation.
    always_comb begin
        tick_wrap = (r_tick >= TCK_W'(TICKS_PER_UPDATE));
        sum_new   = r_sum + SUM_W'(i_q_item.mv[EFF_W-1:0]);
        cnt_new   = r_samples + 1'b1;
        burst_end = (cnt_new >= CNT_W'(SAMPLES_PER_BURST));
    end

    // Digit selection and segment decode for the digit driven next.
    always_comb begin
        dig_prod = {8'd0, r_temp} * {8'd0, DIG_RECIP};
        dec_q    = dig_prod[DIG_SHIFT + 4:DIG_SHIFT];
        dec_r    = r_temp - ({3'd0, dec_q} << 3) - ({3'd0, dec_q} << 1);
        if (r_high_next) begin
            digit = i_cfg.hex_mode ? {1'b0, r_temp[7:4]} : dec_q;
        end else begin
            digit = i_cfg.hex_mode ? {1'b0, r_temp[3:0]} : {1'b0, dec_r[3:0]};
        end
        seg_next = digit[4] ? SEG_BLANK : seg_glyph(digit[3:0]);
    end

    // Rounded average, offset removal with clamp at zero.
    always_comb begin
        round_up = ({i_div_remainder, 1'b0} >= (CNT_W + 1)'(SAMPLES_PER_BURST));
        avg      = D_W'(i_div_quotient[EFF_W-1:0]) + D_W'(round_up);
        zero_ext = D_W'(i_cfg.zero_offset_mv);
        d_next   = (avg < zero_ext) ? '0 : (avg - zero_ext);
    end

    // Divide by ten with half-up rounding and saturation.
    always_comb begin
        q10    = r_prod[PROD_W-1:RECIP10_SHIFT];
        rem10  = r_d - (D_W'(q10) << 3) - (D_W'(q10) << 1);
        t_full = q10 + Q10_W'(rem10 >= D_W'(5));
        t_sat  = (t_full > Q10_W'(TEMP_MAX)) ? TEMP_MAX : t_full[TEMP_W-1:0];
    end

    // Control sequence, architectural state and result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= TCK_W'(TICKS_PER_UPDATE);
            r_high_next <= 1'b0;
            r_sum       <= '0;
            r_samples   <= '0;
            r_temp      <= TEMP_RST;
            r_seg       <= SEG_BLANK;
            r_en        <= 2'b00;
            r_out_valid <= 1'b0;
            r_o_req     <= 1'b0;
            r_o_done    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= burst_pop;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        if (i_q_item.op == OP_TICK) begin
                            if (tick_wrap) begin
                                r_tick    <= '0;
                                r_sum     <= '0;
                                r_samples <= '0;
                            end else begin
                                r_tick <= r_tick + 1'b1;
                            end
                            r_high_next <= !r_high_next;
                            r_en        <= r_high_next ? 2'b10 : 2'b01;
                            r_seg       <= seg_next;
                            r_o_req     <= tick_wrap;
                            r_o_done    <= 1'b0;
                        end else if (burst_end) begin
                            r_sum       <= '0;
                            r_samples   <= '0;
                            r_div_arg   <= sum_new;
                            r_state     <= S_DIV;
                        end else begin
                            r_sum       <= sum_new;
                            r_samples   <= cnt_new;
                            r_o_req     <= 1'b0;
                            r_o_done    <= 1'b0;
                        end
                    end
                end
                S_DIV: begin
                    if (i_div_done) begin
                        r_d     <= d_next;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_prod  <= PROD_W'(r_d) * PROD_W'(RECIP10);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (out_free) begin
                        r_temp      <= t_sat;
                        r_o_req     <= 1'b0;
                        r_o_done    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_q_pop              = pop;
    assign o_div_start          = r_div_start;
    assign o_div_dividend       = r_div_arg;
    assign o_valid              = r_out_valid;
    assign o_segments           = r_seg;
    assign o_tens_on            = r_en[1];
    assign o_ones_on            = r_en[0];
    assign o_conversion_request = r_o_req;
    assign o_temperature_c      = r_temp;
    assign o_update_done        = r_o_done;

    // A burst never holds a full count of samples between items.
    a_samples_below_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_samples < CNT_W'(SAMPLES_PER_BURST))
        else $error("sample count reached the burst length");

    // The tick counter stays within its range.
    a_tick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick <= TCK_W'(TICKS_PER_UPDATE))
        else $error("tick counter out of range");

    // At most one digit display is enabled at a time.
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_en))
        else $error("both digit displays enabled");

    // A request comes from a tick and a finished burst from a sample.
    a_req_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_o_req && r_o_done))
        else $error("result flags request and update together");

    // The divider answers only while a burst is being converted.
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the conversion step");

endmodule

`default_nettype wire

// ===== src/temperature_seven_segment_display.sv =====
// Channel  | valid    | stall    | payload
// ---------+----------+----------+------------------------------------------------
// input    | i_valid  | o_stall  | i_op, i_sample_mv
// result   | o_valid  | i_stall  | o_segments, o_tens_on, o_ones_on,
//          |          |          | o_conversion_request, o_temperature_c,
//          |          |          | o_update_done
// config   | i_cfg_we | (none)   | i_cfg_index, i_cfg_data
//
// A tick, or a sample that does not end a burst, goes from the queue into the result
// register; items can follow one a cycle unless the receiver stalls or a burst is in
// conversion. The sample that ends a burst goes to the reciprocal divide by the burst
// length, then offset removal, the divide by ten and rounding. Reset is synchronous.
// A two-entry queue keeps taking input while a result waits under stall, until full.
`default_nettype none

module temperature_seven_segment_display import tssd_pkg::*; #(
    parameter int SAMPLES_PER_BURST = DEF_SAMPLES_PER_BURST,
    parameter int TICKS_PER_UPDATE  = DEF_TICKS_PER_UPDATE,
    parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_op,
    input  wire logic [MV_W-1:0]      i_sample_mv,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [SEG_W-1:0]          o_segments,
    output logic                      o_tens_on,
    output logic                      o_ones_on,
    output logic                      o_conversion_request,
    output logic [TEMP_W-1:0]         o_temperature_c,
    output logic                      o_update_done
);

    localparam int EFF_W = (SAMPLE_BITS < MV_W) ? SAMPLE_BITS : MV_W;
    localparam int CNT_W = $clog2(SAMPLES_PER_BURST + 1);
    localparam int SUM_W = EFF_W + CNT_W;

    t_cfg             r_cfg;
    logic             q_valid;
    t_item            q_item;
    logic             q_pop;
    logic             div_start;
    logic [SUM_W-1:0] div_dividend;
    logic             div_done;
    logic [SUM_W-1:0] div_quotient;
    logic [CNT_W-1:0] div_remainder;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hex_mode       <= 1'b0;
            r_cfg.zero_offset_mv <= ZERO_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEX_MODE:    r_cfg.hex_mode       <= i_cfg_data[0];
                CFG_ZERO_OFFSET: r_cfg.zero_offset_mv <= i_cfg_data[MV_W-1:0];
                default:         r_cfg                <= r_cfg;
            endcase
        end
    end

    // Front end with the item queue.
    tssd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_sample_mv (i_sample_mv),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    // Burst average divider.
    tssd_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR    (SAMPLES_PER_BURST),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    // Back end with the display state and the result register.
    tssd_back #(
        .SAMPLES_PER_BURST (SAMPLES_PER_BURST),
        .TICKS_PER_UPDATE  (TICKS_PER_UPDATE),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_q_valid            (q_valid),
        .i_q_item             (q_item),
        .o_q_pop              (q_pop),
        .o_div_start          (div_start),
        .o_div_dividend       (div_dividend),
        .i_div_done           (div_done),
        .i_div_quotient       (div_quotient),
        .i_div_remainder      (div_remainder),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_segments           (o_segments),
        .o_tens_on            (o_tens_on),
        .o_ones_on            (o_ones_on),
        .o_conversion_request (o_conversion_request),
        .o_temperature_c      (o_temperature_c),
        .o_update_done        (o_update_done)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the two-digit temperature display: ticks and samples go in,
// and every result transfer is compared with a cycle-free model of the block kept here.
// Depends on tssd_pkg and temperature_seven_segment_display.
module testbench;
    import tssd_pkg::*;

    localparam int BURST        = DEF_SAMPLES_PER_BURST;
    localparam int TICKS        = DEF_TICKS_PER_UPDATE;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 215;

    // One result of the block, as driven on the result channel.
    typedef struct {
        logic [SEG_W-1:0]  segments;
        logic              tens_on;
        logic              ones_on;
        logic              request;
        logic [TEMP_W-1:0] temp;
        logic              done;
    } t_display_frame;

    // Mirror of the display: register copies, state copies and the frames still owed.
    class t_display_mirror;
        bit                hex_mode;
        bit [MV_W-1:0]     zero_offset_mv;
        bit [6:0]          tick_count;
        bit                high_digit_next;
        bit [18:0]         mv_sum;
        bit [6:0]          mv_count;
        bit [TEMP_W-1:0]   temperature;
        bit [SEG_W-1:0]    seg_latch;
        bit [1:0]          digit_enable;
        t_display_frame    pending_frames[$];
        int                errors;

        function new();
            hex_mode        = 1'b0;
            zero_offset_mv  = ZERO_OFFSET_RST;
            tick_count      = 7'(TICKS);
            high_digit_next = 1'b0;
            mv_sum          = '0;
            mv_count        = '0;
            temperature     = TEMP_RST;
            seg_latch       = SEG_BLANK;
            digit_enable    = 2'b00;
            errors          = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_HEX_MODE) begin
                hex_mode = data[0];
            end else if (idx == CFG_ZERO_OFFSET) begin
                zero_offset_mv = data[MV_W-1:0];
            end
        endfunction

        // Active-low glyphs; any digit beyond fifteen blanks the display.
        function bit [SEG_W-1:0] glyph(int unsigned digit);
            case (digit)
                0: return 8'hC0;
                1: return 8'hF9;
                2: return 8'hA4;
                3: return 8'hB0;
                4: return 8'h99;
                5: return 8'h92;
                6: return 8'h82;
                7: return 8'hF8;
                8: return 8'h80;
                9: return 8'h90;
                10: return 8'h08;
                11: return 8'h03;
                12: return 8'h46;
                13: return 8'h21;
                14: return 8'h06;
                15: return 8'h0E;
                default: return SEG_BLANK;
            endcase
        endfunction

        // Rounded burst average, minus the offset, in rounded tenths, clamped to 0..255.
        function bit [TEMP_W-1:0] celsius(bit [18:0] total);
            int unsigned avg, rem, d, t;
            avg = total / BURST;
            rem = total % BURST;
            if (2 * rem >= BURST) avg++;
            if (avg < zero_offset_mv) return '0;
            d = avg - zero_offset_mv;
            t = d / 10 + ((d % 10 >= 5) ? 1 : 0);
            return (t > 255) ? TEMP_MAX : TEMP_W'(t);
        endfunction

        // Advance the mirror by one accepted item and queue the frame it owes.
        function void take_item(t_op op, logic [MV_W-1:0] mv);
            t_display_frame f;
            int unsigned    base, digit;
            f.request = 1'b0;
            f.done    = 1'b0;
            if (op == OP_TICK) begin
                if (tick_count >= TICKS) begin
                    f.request  = 1'b1;
                    tick_count = '0;
                    mv_sum     = '0;
                    mv_count   = '0;
                end else begin
                    tick_count++;
                end
                base = hex_mode ? 16 : 10;
                if (high_digit_next) begin
                    digit           = temperature / base;
                    digit_enable    = 2'b10;
                    high_digit_next = 1'b0;
                end else begin
                    digit           = temperature % base;
                    digit_enable    = 2'b01;
                    high_digit_next = 1'b1;
                end
                seg_latch = glyph(digit);
            end else begin
                mv_sum += mv;
                mv_count++;
                if (mv_count >= BURST) begin
                    temperature = celsius(mv_sum);
                    mv_sum      = '0;
                    mv_count    = '0;
                    f.done      = 1'b1;
                end
            end
            f.segments = seg_latch;
            f.tens_on  = digit_enable[1];
            f.ones_on  = digit_enable[0];
            f.temp     = temperature;
            pending_frames.push_back(f);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 60) $display("mismatch: %s", what);
        endtask

        // Compare one result transfer with the oldest frame owed.
        task check_frame(t_display_frame got);
            t_display_frame want;
            if (pending_frames.size() == 0) begin
                report("result transfer with no item outstanding");
                return;
            end
            want = pending_frames.pop_front();
            if (got.segments !== want.segments)
                report($sformatf("segments %h, expected %h", got.segments, want.segments));
            if (got.tens_on !== want.tens_on)
                report($sformatf("tens_on %b, expected %b", got.tens_on, want.tens_on));
            if (got.ones_on !== want.ones_on)
                report($sformatf("ones_on %b, expected %b", got.ones_on, want.ones_on));
            if (got.request !== want.request)
                report($sformatf("conversion_request %b, expected %b", got.request,
                                 want.request));
            if (got.temp !== want.temp)
                report($sformatf("temperature_c %0d, expected %0d", got.temp, want.temp));
            if (got.done !== want.done)
                report($sformatf("update_done %b, expected %b", got.done, want.done));
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_HEX_MODE;
    logic [CFG_W-1:0]      i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    t_op                   i_op        = OP_TICK;
    logic [MV_W-1:0]       i_sample_mv = '0;
    logic                  i_stall     = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [SEG_W-1:0]      o_segments;
    logic                  o_tens_on;
    logic                  o_ones_on;
    logic                  o_conversion_request;
    logic [TEMP_W-1:0]     o_temperature_c;
    logic                  o_update_done;

    t_display_mirror mirror;
    int              idle_pct    = 0;
    int              stall_pct   = 0;
    int              hold_cycles = 0;

    temperature_seven_segment_display #(
        .SAMPLES_PER_BURST (DEF_SAMPLES_PER_BURST),
        .TICKS_PER_UPDATE  (DEF_TICKS_PER_UPDATE),
        .SAMPLE_BITS       (DEF_SAMPLE_BITS)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_op                 (i_op),
        .i_sample_mv          (i_sample_mv),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_segments           (o_segments),
        .o_tens_on            (o_tens_on),
        .o_ones_on            (o_ones_on),
        .o_conversion_request (o_conversion_request),
        .o_temperature_c      (o_temperature_c),
        .o_update_done        (o_update_done)
    );

    always #6 i_clk = ~i_clk;

    // Receiver stall: a requested hold-off first, otherwise random at the phase rate.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Every result transfer is checked at the edge that completes it.
    always @(posedge i_clk) begin : result_monitor
        t_display_frame got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.segments = o_segments;
            got.tens_on  = o_tens_on;
            got.ones_on  = o_ones_on;
            got.request  = o_conversion_request;
            got.temp     = o_temperature_c;
            got.done     = o_update_done;
            mirror.check_frame(got);
        end
    end

    // Offer one item, with random idle cycles ahead of it, and hold it until transferred.
    task automatic send_item(input t_op op, input logic [MV_W-1:0] mv);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_sample_mv <= mv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        mirror.take_item(op, mv);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every owed frame has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (mirror.pending_frames.size() != 0);
    endtask

    // Write both registers while the block is idle.
    task automatic configure(input logic hex, input logic [MV_W-1:0] offset);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HEX_MODE;
        i_cfg_data  <= CFG_W'(hex);
        mirror.write_reg(CFG_HEX_MODE, CFG_W'(hex));
        @(negedge i_clk);
        i_cfg_index <= CFG_ZERO_OFFSET;
        i_cfg_data  <= offset;
        mirror.write_reg(CFG_ZERO_OFFSET, offset);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random ticks between runs of samples that hover around a level for one burst.
    task automatic run_phase(input int items, input int tick_pct, input int pause_at);
        int              level;
        int              span_left;
        int              jitter;
        logic [MV_W-1:0] mv;
        level     = 0;
        span_left = 0;
        for (int n = 0; n < items; n++) begin
            if (n == pause_at) wait_drained();
            if ($urandom_range(99) < tick_pct) begin
                send_item(OP_TICK, MV_W'($urandom_range(4095)));
            end else begin
                if (span_left == 0) begin
                    span_left = BURST;
                    if ($urandom_range(1) == 1)
                        level = int'($urandom_range(4095));
                    else
                        level = int'(mirror.zero_offset_mv) + int'($urandom_range(1200));
                end
                span_left--;
                if ($urandom_range(9) == 0) begin
                    mv = MV_W'($urandom_range(4095));
                end else begin
                    jitter = level + int'($urandom_range(20)) - 10;
                    mv = (jitter < 0) ? '0 : (jitter > 4095) ? 12'hFFF : MV_W'(jitter);
                end
                send_item(OP_SAMPLE, mv);
            end
        end
        wait_drained();
    endtask

    initial begin : main_sequence
        mirror = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        configure(1'b0, 12'd500);

        // Directed: first tick requests, both digits of the reset value, extreme samples,
        // and a tick carrying a sample field that must be ignored.
        send_item(OP_TICK, 12'hFFF);
        send_item(OP_TICK, 12'h000);
        send_item(OP_SAMPLE, 12'h000);
        send_item(OP_SAMPLE, 12'hFFF);
        send_item(OP_SAMPLE, 12'hAAA);
        send_item(OP_SAMPLE, 12'h555);
        send_item(OP_SAMPLE, 12'h001);
        send_item(OP_SAMPLE, 12'h800);
        send_item(OP_TICK, 12'hAAA);
        send_item(OP_TICK, 12'h555);
        send_item(OP_TICK, 12'h000);
        send_item(OP_SAMPLE, 12'h7FF);
        send_item(OP_TICK, 12'hFFF);
        wait_drained();

        // No idling, decimal digits, zero offset so temperatures can saturate.
        configure(1'b0, 12'd0);
        run_phase(PHASE_ITEMS, 30, -1);

        // Sender mostly idle, hex digits, largest offset.
        idle_pct = 77;
        configure(1'b1, 12'hFFF);
        run_phase(PHASE_ITEMS, 30, -1);

        // Receiver mostly stalling, hex digits, zero offset.
        idle_pct  = 0;
        stall_pct = 77;
        configure(1'b1, 12'd0);
        run_phase(PHASE_ITEMS, 25, -1);

        // Both sides idling now and then, decimal digits, random offset.
        idle_pct  = 30;
        stall_pct = 30;
        configure(1'b0, MV_W'($urandom_range(4095)));
        run_phase(PHASE_ITEMS, 50, -1);

        // Long receiver hold-off so the block fills and stalls its input, then a
        // mid-phase pause until every frame has come back.
        idle_pct    = 0;
        stall_pct   = 0;
        configure(1'b0, 12'd500);
        hold_cycles = 80;
        run_phase(PHASE_ITEMS, 25, PHASE_ITEMS / 2);

        // Mixed idling again with a random setting.
        idle_pct  = 30;
        stall_pct = 30;
        configure(1'($urandom_range(1)), MV_W'($urandom_range(1500)));
        run_phase(PHASE_ITEMS, 30, -1);

        // Give a late or spurious transfer time to show up.
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mirror.pending_frames.size() != 0) mirror.report("frames still owed at the end");
        if (mirror.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Ends a run that hangs.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end
endmodule
